// ===== design/gpb_pkg.sv =====
// Shared types and constants for the GPIO port interrupt bank.
`default_nettype none

package gpb_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PIN   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_PINS_IN_USE  = 2'd0;
    localparam logic [1:0] CFG_RESET_LEVELS = 2'd1;

    localparam logic [3:0] PINS_IN_USE_RESET = 4'd8;

    localparam logic [11:0] OFF_DATA     = 12'h000;
    localparam logic [11:0] OFF_DIR      = 12'h004;
    localparam logic [11:0] OFF_ENABLE   = 12'h030;
    localparam logic [11:0] OFF_MASK     = 12'h034;
    localparam logic [11:0] OFF_EDGE     = 12'h038;
    localparam logic [11:0] OFF_POLARITY = 12'h03C;
    localparam logic [11:0] OFF_STATUS   = 12'h040;
    localparam logic [11:0] OFF_RAW      = 12'h044;
    localparam logic [11:0] OFF_DEBOUNCE = 12'h048;
    localparam logic [11:0] OFF_EOI      = 12'h04C;
    localparam logic [11:0] OFF_LEVEL    = 12'h050;
    localparam logic [11:0] OFF_SYNC     = 12'h060;
    localparam logic [11:0] OFF_BOTH     = 12'h068;
    localparam logic [11:0] OFF_VERSION  = 12'h06C;

    localparam logic [31:0] VERSION_WORD = 32'h3231_342A;

    typedef struct packed {
        cmd_t        cmd;
        logic [11:0] offset;
        logic [31:0] wdata;
        logic [2:0]  pin;
        logic        level;
    } item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [7:0]  irq_lines;
    } result_t;

endpackage

`default_nettype wire

// ===== design/gpb_ifs.sv =====
// Channel interfaces: item input, result output and configuration write.
`default_nettype none

interface gpb_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [11:0] offset;
    logic [31:0] wdata;
    logic [2:0]  pin;
    logic        level;

    modport source (output valid, cmd, offset, wdata, pin, level, input ready);
    modport sink (input valid, cmd, offset, wdata, pin, level, output ready);
    modport monitor (input valid, ready, cmd, offset, wdata, pin, level);
endinterface

interface gpb_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic [7:0]  irq_lines;

    modport source (output valid, rdata, irq_lines, input ready);
    modport sink (input valid, rdata, irq_lines, output ready);
    modport monitor (input valid, ready, rdata, irq_lines);
endinterface

interface gpb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/gpio_port_interrupt_bank_core.sv =====
// Top level of the GPIO port interrupt bank.
// An item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless results stall; the register bank updates in one pass.
// The configuration channel is ready whenever no item moves into the result register.
// Reset: asynchronous active low; registers and raw interrupts clear, input levels load
// zero, pins_in_use loads 8, both stages empty.
`default_nettype none

module gpio_port_interrupt_bank_core #(
    parameter int PINS = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    gpb_item_if.sink       item_in,
    gpb_result_if.source   result_out,
    gpb_cfg_if.sink        cfg
);

    logic             proc;
    logic             advance;
    logic             cfg_fire;
    gpb_pkg::item_t   item;
    gpb_pkg::result_t result;

    assign cfg.ready = !proc;
    assign cfg_fire  = cfg.valid && cfg.ready;

    gpb_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .advance (advance),
        .proc    (proc),
        .item    (item)
    );

    gpb_regfile #(
        .PINS (PINS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .item      (item),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .result    (result)
    );

    gpb_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc       (proc),
        .result     (result),
        .advance    (advance),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// ===== design/gpb_in_stage.sv =====
// Input register stage for incoming items.
`default_nettype none

module gpb_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    gpb_item_if.sink            item_in,
    input  wire logic           advance,
    output logic                proc,
    output gpb_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    gpb_pkg::item_t item_reg;

    assign item_in.ready = !valid_reg || advance;
    assign proc          = valid_reg && advance;
    assign item          = item_reg;
    assign valid_next    = item_in.ready ? item_in.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            item_reg.cmd    <= gpb_pkg::cmd_t'(item_in.cmd);
            item_reg.offset <= item_in.offset;
            item_reg.wdata  <= item_in.wdata;
            item_reg.pin    <= item_in.pin;
            item_reg.level  <= item_in.level;
        end
    end

endmodule

`default_nettype wire

// ===== design/gpb_regfile.sv =====
// Register bank, interrupt logic and read mux.
`default_nettype none

module gpb_regfile #(
    parameter int PINS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             proc,
    input  wire gpb_pkg::item_t   item,
    input  wire logic             cfg_fire,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    output gpb_pkg::result_t      result
);

    logic [PINS-1:0] dout_reg, dout_next;
    logic [PINS-1:0] dir_reg, dir_next;
    logic [PINS-1:0] en_reg, en_next;
    logic [PINS-1:0] mask_reg, mask_next;
    logic [PINS-1:0] edge_reg, edge_next;
    logic [PINS-1:0] pol_reg, pol_next;
    logic [PINS-1:0] both_reg, both_next;
    logic [PINS-1:0] deb_reg, deb_next;
    logic [PINS-1:0] sync_reg, sync_next;
    logic [PINS-1:0] ext_reg, ext_next;
    logic [PINS-1:0] raw_reg, raw_next;
    logic [3:0]      piu_reg, piu_next;

    logic [PINS-1:0] lv_cur, lv_after, lv_new;
    logic [PINS-1:0] wval, pin_bit, ext_pin;
    logic [PINS-1:0] rise, fall, edges;
    logic [PINS-1:0] em_new, match, status;
    logic [7:0]      status8;
    logic [7:0]      irq;
    logic [31:0]     rd;
    logic            write_hit;
    logic            eval;

    always_comb
    begin
        dout_next = dout_reg;
        dir_next  = dir_reg;
        en_next   = en_reg;
        mask_next = mask_reg;
        edge_next = edge_reg;
        pol_next  = pol_reg;
        both_next = both_reg;
        deb_next  = deb_reg;
        sync_next = sync_reg;
        ext_next  = ext_reg;
        raw_next  = raw_reg;
        piu_next  = piu_reg;
        rd        = '0;
        write_hit = 1'b0;
        eval      = 1'b0;

        lv_cur = (dout_reg & dir_reg) | (ext_reg & ~dir_reg);
        wval   = PINS'(item.wdata);
        for (int i = 0; i < PINS; i++)
        begin
            pin_bit[i] = (32'(item.pin) == i);
        end
        ext_pin  = (ext_reg & ~pin_bit) | (item.level ? pin_bit : '0);
        lv_after = (dout_reg & dir_reg) | (ext_pin & ~dir_reg);
        rise     = lv_after & ~lv_cur;
        fall     = lv_cur & ~lv_after;
        edges    = (both_reg & (rise | fall))
                 | (~both_reg & ((pol_reg & rise) | (~pol_reg & fall)));

        if (proc)
        begin
            case (item.cmd)
                gpb_pkg::CMD_READ:
                begin
                    case (item.offset)
                        gpb_pkg::OFF_DATA:     rd = 32'(dout_reg);
                        gpb_pkg::OFF_DIR:      rd = 32'(dir_reg);
                        gpb_pkg::OFF_ENABLE:   rd = 32'(en_reg);
                        gpb_pkg::OFF_MASK:     rd = 32'(mask_reg);
                        gpb_pkg::OFF_EDGE:     rd = 32'(edge_reg);
                        gpb_pkg::OFF_POLARITY: rd = 32'(pol_reg);
                        gpb_pkg::OFF_STATUS:   rd = 32'(raw_reg & en_reg & ~mask_reg);
                        gpb_pkg::OFF_RAW:      rd = 32'(raw_reg);
                        gpb_pkg::OFF_DEBOUNCE: rd = 32'(deb_reg);
                        gpb_pkg::OFF_LEVEL:    rd = 32'(lv_cur);
                        gpb_pkg::OFF_SYNC:     rd = 32'(sync_reg);
                        gpb_pkg::OFF_BOTH:     rd = 32'(both_reg);
                        gpb_pkg::OFF_VERSION:  rd = gpb_pkg::VERSION_WORD;
                        default:               rd = '0;
                    endcase
                end
                gpb_pkg::CMD_WRITE:
                begin
                    write_hit = 1'b1;
                    case (item.offset)
                        gpb_pkg::OFF_DATA:     dout_next = wval;
                        gpb_pkg::OFF_DIR:      dir_next  = wval;
                        gpb_pkg::OFF_ENABLE:   en_next   = wval;
                        gpb_pkg::OFF_MASK:     mask_next = wval;
                        gpb_pkg::OFF_EDGE:     edge_next = wval;
                        gpb_pkg::OFF_POLARITY: pol_next  = wval;
                        gpb_pkg::OFF_DEBOUNCE: deb_next  = wval;
                        gpb_pkg::OFF_EOI:      raw_next  = raw_reg & ~wval;
                        gpb_pkg::OFF_SYNC:     sync_next = wval;
                        gpb_pkg::OFF_BOTH:     both_next = wval;
                        default:               write_hit = 1'b0;
                    endcase
                    eval = write_hit;
                end
                gpb_pkg::CMD_PIN:
                begin
                    ext_next = ext_pin;
                    raw_next = raw_reg
                             | (edges & (edge_reg | both_reg) & en_reg & pin_bit);
                    eval     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                gpb_pkg::CFG_PINS_IN_USE:
                begin
                    piu_next = cfg_data[3:0];
                end
                gpb_pkg::CFG_RESET_LEVELS:
                begin
                    ext_next = PINS'(32'(cfg_data));
                    eval     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        lv_new = (dout_next & dir_next) | (ext_next & ~dir_next);
        em_new = edge_next | both_next;
        match  = ~(pol_next ^ lv_new);
        if (eval)
        begin
            raw_next = (raw_next & em_new & en_next) | (~em_new & en_next & match);
        end

        status  = raw_next & en_next & ~mask_next;
        status8 = 8'(32'(status));
        for (int i = 0; i < 8; i++)
        begin
            irq[i] = status8[i] && (4'(i) < piu_next);
        end
    end

    assign result.rdata     = rd;
    assign result.irq_lines = irq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
            dir_reg  <= '0;
            en_reg   <= '0;
            mask_reg <= '0;
            edge_reg <= '0;
            pol_reg  <= '0;
            both_reg <= '0;
            deb_reg  <= '0;
            sync_reg <= '0;
            ext_reg  <= '0;
            raw_reg  <= '0;
            piu_reg  <= gpb_pkg::PINS_IN_USE_RESET;
        end
        else
        begin
            dout_reg <= dout_next;
            dir_reg  <= dir_next;
            en_reg   <= en_next;
            mask_reg <= mask_next;
            edge_reg <= edge_next;
            pol_reg  <= pol_next;
            both_reg <= both_next;
            deb_reg  <= deb_next;
            sync_reg <= sync_next;
            ext_reg  <= ext_next;
            raw_reg  <= raw_next;
            piu_reg  <= piu_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/gpb_out_stage.sv =====
// Result register stage for outgoing items.
`default_nettype none

module gpb_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             proc,
    input  wire gpb_pkg::result_t result,
    output logic                  advance,
    gpb_result_if.source          result_out
);

    logic             valid_reg;
    logic             valid_next;
    gpb_pkg::result_t result_reg;

    assign advance              = !valid_reg || result_out.ready;
    assign valid_next           = advance ? proc : valid_reg;
    assign result_out.valid     = valid_reg;
    assign result_out.rdata     = result_reg.rdata;
    assign result_out.irq_lines = result_reg.irq_lines;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== design/gpb_checker.sv =====
// Port checker for the GPIO port interrupt bank, bound to the top level.
`default_nettype none

module gpb_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_ready,
    input  wire logic        result_valid,
    input  wire logic        result_ready,
    input  wire logic [31:0] result_rdata,
    input  wire logic [7:0]  result_irq_lines
);

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled while result stage empty");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(result_rdata) && $stable(result_irq_lines))
        else $error("result payload changed while stalled");

endmodule

bind gpio_port_interrupt_bank_core gpb_checker u_gpb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_ready       (item_in.ready),
    .result_valid     (result_out.valid),
    .result_ready     (result_out.ready),
    .result_rdata     (result_out.rdata),
    .result_irq_lines (result_out.irq_lines)
);

`default_nettype wire

// ===== test/gpio_port_interrupt_bank_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench: random bus and pin traffic against a shadow of the GPIO interrupt bank.
`default_nettype none

module gpio_port_interrupt_bank_core_tb;

    localparam int BANK_PINS   = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int RX_HOLD     = 300;
    localparam int SETTLE      = 6;
    localparam int PHASE_ITEMS = 125;

    class gpio_bank_mirror;
        localparam int LINES = 8;

        logic [3:0]       pins_in_use;
        logic [7:0]       data_out, direction, irq_enable, irq_mask, edge_type, polarity;
        logic [7:0]       both_edges, debounce_bits, level_sync, ext_levels, raw_irq;
        gpb_pkg::result_t expected_replies[$];
        int               mismatches;

        function new();
            pins_in_use   = gpb_pkg::PINS_IN_USE_RESET;
            data_out      = '0;
            direction     = '0;
            irq_enable    = '0;
            irq_mask      = '0;
            edge_type     = '0;
            polarity      = '0;
            both_edges    = '0;
            debounce_bits = '0;
            level_sync    = '0;
            ext_levels    = '0;
            raw_irq       = '0;
            mismatches    = 0;
            settle_levels();
        endfunction

        function logic [7:0] pin_levels();
            return (data_out & direction) | (ext_levels & ~direction);
        endfunction

        function logic [7:0] edge_pins();
            return edge_type | both_edges;
        endfunction

        function logic [7:0] masked_status();
            return raw_irq & irq_enable & ~irq_mask;
        endfunction

        function void settle_levels();
            logic [7:0] lv;
            logic [7:0] em;
            logic [7:0] match_bits;
            lv = pin_levels();
            em = edge_pins();
            match_bits = (polarity & lv) | (~polarity & ~lv);
            raw_irq = (raw_irq & em & irq_enable) | (~em & irq_enable & match_bits);
        endfunction

        function logic [7:0] irq_lines_now();
            int         n;
            logic [8:0] lines;
            n = (pins_in_use > LINES) ? LINES : int'(pins_in_use);
            lines = (9'd1 << n) - 9'd1;
            return masked_status() & lines[7:0];
        endfunction

        function logic [31:0] bus_read(logic [11:0] off);
            case (off)
                gpb_pkg::OFF_DATA:     return 32'(data_out);
                gpb_pkg::OFF_DIR:      return 32'(direction);
                gpb_pkg::OFF_ENABLE:   return 32'(irq_enable);
                gpb_pkg::OFF_MASK:     return 32'(irq_mask);
                gpb_pkg::OFF_EDGE:     return 32'(edge_type);
                gpb_pkg::OFF_POLARITY: return 32'(polarity);
                gpb_pkg::OFF_STATUS:   return 32'(masked_status());
                gpb_pkg::OFF_RAW:      return 32'(raw_irq);
                gpb_pkg::OFF_DEBOUNCE: return 32'(debounce_bits);
                gpb_pkg::OFF_LEVEL:    return 32'(pin_levels());
                gpb_pkg::OFF_SYNC:     return 32'(level_sync);
                gpb_pkg::OFF_BOTH:     return 32'(both_edges);
                gpb_pkg::OFF_VERSION:  return gpb_pkg::VERSION_WORD;
                default:               return '0;
            endcase
        endfunction

        function void bus_write(logic [11:0] off, logic [31:0] wd);
            logic [7:0] v;
            v = wd[7:0];
            case (off)
                gpb_pkg::OFF_DATA:     data_out = v;
                gpb_pkg::OFF_DIR:      direction = v;
                gpb_pkg::OFF_ENABLE:   irq_enable = v;
                gpb_pkg::OFF_MASK:     irq_mask = v;
                gpb_pkg::OFF_EDGE:     edge_type = v;
                gpb_pkg::OFF_POLARITY: polarity = v;
                gpb_pkg::OFF_DEBOUNCE: debounce_bits = v;
                gpb_pkg::OFF_EOI:      raw_irq = raw_irq & ~v;
                gpb_pkg::OFF_SYNC:     level_sync = v;
                gpb_pkg::OFF_BOTH:     both_edges = v;
                default:               return;
            endcase
            settle_levels();
        endfunction

        function void pin_change(logic [2:0] pin, logic lvl);
            logic [7:0] pin_bit;
            logic [7:0] was;
            logic [7:0] now;
            logic [7:0] rise;
            logic [7:0] fall;
            logic [7:0] edges;
            pin_bit = 8'd1 << pin;
            was = pin_levels();
            ext_levels = lvl ? (ext_levels | pin_bit) : (ext_levels & ~pin_bit);
            now = pin_levels();
            rise = now & ~was;
            fall = was & ~now;
            edges = (both_edges & (rise | fall)) |
                    (~both_edges & ((polarity & rise) | (~polarity & fall)));
            raw_irq = raw_irq | (edges & edge_pins() & irq_enable & pin_bit);
            settle_levels();
        endfunction

        function void take_setting(logic [1:0] index, logic [7:0] value);
            if (index == gpb_pkg::CFG_PINS_IN_USE)
            begin
                pins_in_use = value[3:0];
            end
            else if (index == gpb_pkg::CFG_RESET_LEVELS)
            begin
                ext_levels = value;
                settle_levels();
            end
        endfunction

        function void take_item(gpb_pkg::item_t it);
            gpb_pkg::result_t r;
            r.rdata = '0;
            case (it.cmd)
                gpb_pkg::CMD_READ:  r.rdata = bus_read(it.offset);
                gpb_pkg::CMD_WRITE: bus_write(it.offset, it.wdata);
                gpb_pkg::CMD_PIN:   pin_change(it.pin, it.level);
                default:            ;
            endcase
            r.irq_lines = irq_lines_now();
            expected_replies.push_back(r);
        endfunction

        function void check_reply(gpb_pkg::result_t got);
            gpb_pkg::result_t want;
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result: rdata %h irq_lines %h", got.rdata, got.irq_lines);
                mismatches++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.rdata !== want.rdata)
            begin
                $error("rdata: expected %h, actual %h", want.rdata, got.rdata);
                mismatches++;
            end
            if (got.irq_lines !== want.irq_lines)
            begin
                $error("irq_lines: expected %h, actual %h", want.irq_lines, got.irq_lines);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gpb_item_if   item_ch ();
    gpb_result_if result_ch ();
    gpb_cfg_if    cfg_ch ();

    gpio_port_interrupt_bank_core #(
        .PINS(BANK_PINS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_ch),
        .result_out(result_ch),
        .cfg       (cfg_ch)
    );

    gpio_bank_mirror mirror = new();

    int               tx_idle_pct;
    int               rx_stall_pct;
    int               rx_hold_cycles;
    int               quiet_cycles;
    gpb_pkg::item_t   seen_item;
    gpb_pkg::result_t seen_reply;

    logic [11:0] reg_offsets [14] = '{gpb_pkg::OFF_DATA, gpb_pkg::OFF_DIR, gpb_pkg::OFF_ENABLE,
                                      gpb_pkg::OFF_MASK, gpb_pkg::OFF_EDGE,
                                      gpb_pkg::OFF_POLARITY, gpb_pkg::OFF_STATUS,
                                      gpb_pkg::OFF_RAW, gpb_pkg::OFF_DEBOUNCE,
                                      gpb_pkg::OFF_EOI, gpb_pkg::OFF_LEVEL,
                                      gpb_pkg::OFF_SYNC, gpb_pkg::OFF_BOTH,
                                      gpb_pkg::OFF_VERSION};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                mirror.take_setting(cfg_ch.index, cfg_ch.data);
            if (item_ch.valid && item_ch.ready)
            begin
                seen_item.cmd    = gpb_pkg::cmd_t'(item_ch.cmd);
                seen_item.offset = item_ch.offset;
                seen_item.wdata  = item_ch.wdata;
                seen_item.pin    = item_ch.pin;
                seen_item.level  = item_ch.level;
                mirror.take_item(seen_item);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                seen_reply.rdata     = result_ch.rdata;
                seen_reply.irq_lines = result_ch.irq_lines;
                mirror.check_reply(seen_reply);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input gpb_pkg::item_t it);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.cmd    <= it.cmd;
        item_ch.offset <= it.offset;
        item_ch.wdata  <= it.wdata;
        item_ch.pin    <= it.pin;
        item_ch.level  <= it.level;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_op(input gpb_pkg::cmd_t cmd, input logic [11:0] off,
                           input logic [31:0] wd, input logic [2:0] pin, input logic lvl);
        gpb_pkg::item_t it;
        it.cmd    = cmd;
        it.offset = off;
        it.wdata  = wd;
        it.pin    = pin;
        it.level  = lvl;
        send_item(it);
    endtask

    task automatic write_setting(input logic [1:0] index, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pause_until_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.expected_replies.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic gpb_pkg::item_t random_item();
        gpb_pkg::item_t it;
        int             pick;
        pick = $urandom_range(99);
        if (pick < 38)
            it.cmd = gpb_pkg::CMD_PIN;
        else if (pick < 68)
            it.cmd = gpb_pkg::CMD_WRITE;
        else if (pick < 97)
            it.cmd = gpb_pkg::CMD_READ;
        else
            it.cmd = gpb_pkg::CMD_NOP;
        if ($urandom_range(9) == 0)
            it.offset = 12'($urandom);
        else
            it.offset = reg_offsets[$urandom_range(13)];
        case ($urandom_range(9))
            0:       it.wdata = '0;
            1:       it.wdata = '1;
            default: it.wdata = $urandom;
        endcase
        it.pin   = 3'($urandom_range(7));
        it.level = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic run_directed();
        send_op(gpb_pkg::CMD_READ,  gpb_pkg::OFF_VERSION,  32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_READ,  gpb_pkg::OFF_EOI,      32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_READ,  12'hFFF,               32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_READ,  12'h001,               32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_ENABLE,   32'hFFFF_FFFF, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_STATUS,   32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_VERSION,  32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, 12'hABC,               32'hFFFF_FFFF, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_EDGE,     32'h0000_000F, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_EOI,      32'hFFFF_FF0F, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_BOTH,     32'h0000_0030, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_POLARITY, 32'h0000_0005, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_PIN,   12'h000,               32'h0,         3'd0, 1'b1);
        send_op(gpb_pkg::CMD_PIN,   12'h000,               32'h0,         3'd1, 1'b1);
        send_op(gpb_pkg::CMD_PIN,   12'h000,               32'h0,         3'd1, 1'b0);
        send_op(gpb_pkg::CMD_PIN,   12'h000,               32'h0,         3'd4, 1'b1);
        send_op(gpb_pkg::CMD_PIN,   12'h000,               32'h0,         3'd7, 1'b1);
        send_op(gpb_pkg::CMD_READ,  gpb_pkg::OFF_RAW,      32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_READ,  gpb_pkg::OFF_STATUS,   32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_MASK,     32'h0000_0011, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_DIR,      32'h0000_00F0, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_DATA,     32'hA5A5_A5A5, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_READ,  gpb_pkg::OFF_LEVEL,    32'h0,         3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_DEBOUNCE, 32'h0000_005A, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_WRITE, gpb_pkg::OFF_SYNC,     32'h0000_00C3, 3'd0, 1'b0);
        send_op(gpb_pkg::CMD_NOP,   12'hFFF,               32'hFFFF_FFFF, 3'd7, 1'b1);
    endtask

    initial
    begin
        int phase;
        int n;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rx_hold_cycles = 0;
        quiet_cycles   = 0;
        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.cmd    <= gpb_pkg::CMD_READ;
        item_ch.offset <= '0;
        item_ch.wdata  <= '0;
        item_ch.pin    <= '0;
        item_ch.level  <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= gpb_pkg::CFG_PINS_IN_USE;
        cfg_ch.data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h08);
        write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'h00);
        run_directed();

        for (phase = 0; phase < 8; phase++)
        begin
            pause_until_drained();
            case (phase)
                0:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h00);
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'hFF);
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                1:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h0F);
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'h00);
                    tx_idle_pct = 49; rx_stall_pct = 0;
                end
                2:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h93);
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'($urandom));
                    tx_idle_pct = 0;  rx_stall_pct = 49;
                end
                3:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h08);
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'hFF);
                    tx_idle_pct = 10; rx_stall_pct = 10;
                end
                4:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'($urandom_range(15)));
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'($urandom));
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                5:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h01);
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'($urandom));
                    tx_idle_pct = 49; rx_stall_pct = 0;
                end
                6:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'h07);
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'h00);
                    tx_idle_pct = 0;  rx_stall_pct = 49;
                end
                default:
                begin
                    write_setting(gpb_pkg::CFG_PINS_IN_USE, 8'($urandom));
                    write_setting(gpb_pkg::CFG_RESET_LEVELS, 8'($urandom));
                    tx_idle_pct = 10; rx_stall_pct = 10;
                end
            endcase

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == 0)
                    rx_hold_cycles = RX_HOLD;
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    pause_until_drained();
                send_item(random_item());
            end
        end

        pause_until_drained();
        if (mirror.mismatches == 0 && mirror.expected_replies.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== gpio_port_interrupt_bank_core.f =====
design/gpb_pkg.sv
design/gpb_ifs.sv
design/gpb_in_stage.sv
design/gpb_regfile.sv
design/gpb_out_stage.sv
design/gpio_port_interrupt_bank_core.sv
design/gpb_checker.sv
test/gpio_port_interrupt_bank_core_tb.sv
